// ===== rtl/sample_fault_latch_shutoff_retry_unit_assert.svh =====
// Assertion macros used by the port-level checker of the sampling fault supervisor.
`ifndef SAMPLE_FAULT_LATCH_SHUTOFF_RETRY_UNIT_ASSERT_SVH
`define SAMPLE_FAULT_LATCH_SHUTOFF_RETRY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfls assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfls assertion failed");

`endif

// ===== rtl/sfls_pkg.sv =====
// Types, constants and helper functions of the sampling fault supervisor.
`timescale 1ns / 1ps

package sfls_pkg;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        KIND_SAMPLE_OK   = 2'd0,
        KIND_SAMPLE_FAIL = 2'd1,
        KIND_TAKE        = 2'd2,
        KIND_COMMIT      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ENTER   = 3'd1,
        ACT_RECOVER = 3'd2,
        ACT_SHUTOFF = 3'd3,
        ACT_RETRY   = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAIL_LIMIT    = 3'd0,
        REG_RETRY_LIMIT   = 3'd1,
        REG_RECOVER_LIMIT = 3'd2,
        REG_AUTO_RECOVER  = 3'd3,
        REG_SHUTOFF_CODE  = 3'd4,
        REG_SHUTOFF_STAGE = 3'd5
    } reg_idx_t;

    localparam logic [7:0] FAIL_LIMIT_RST    = 8'd3;
    localparam logic [7:0] RETRY_LIMIT_RST   = 8'd3;
    localparam logic [7:0] RECOVER_LIMIT_RST = 8'd10;
    localparam logic       AUTO_RECOVER_RST  = 1'b0;
    localparam logic [7:0] SHUTOFF_CODE_RST  = 8'd1;
    localparam logic [7:0] SHUTOFF_STAGE_RST = 8'd1;

    localparam logic [7:0]  NONE_CODE = 8'd0;
    localparam logic [7:0]  SAT8_MAX  = 8'd255;
    localparam logic [15:0] SAT16_MAX = 16'd65535;

    typedef struct packed {
        logic [7:0] fail_limit;
        logic [7:0] retry_limit;
        logic [7:0] recover_limit;
        logic       auto_recover;
        logic [7:0] shutoff_code;
        logic [7:0] shutoff_stage;
    } cfg_t;

    typedef struct packed {
        logic [7:0] err_code;
        logic [7:0] err_stage;
        logic [7:0] shutoff_status;
    } item_t;

    typedef struct packed {
        logic        latched;
        logic        request;
        logic        done;
        logic        gave_up;
        logic [7:0]  fail_streak;
        logic [7:0]  success_streak;
        logic [7:0]  retries;
        logic [15:0] sample_total;
        logic [15:0] shutoff_total;
        logic [7:0]  code;
        logic [7:0]  stage;
    } state_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v < SAT8_MAX) ? v + 8'd1 : v;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v < SAT16_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

// ===== rtl/sfls_update.sv =====
// Next-state and action logic of the supervisor for one event.
`timescale 1ns / 1ps

module sfls_update (
    input  sfls_pkg::cfg_t    cfg,
    input  sfls_pkg::state_t  cur,
    input  sfls_pkg::kind_t   kind,
    input  sfls_pkg::item_t   item,
    output sfls_pkg::state_t  nxt,
    output sfls_pkg::action_t action
);
    import sfls_pkg::*;

    logic [7:0] fs_inc;
    logic [7:0] ss_inc;
    logic [7:0] retry_inc;

    assign fs_inc    = sat_inc8(cur.fail_streak);
    assign ss_inc    = sat_inc8(cur.success_streak);
    assign retry_inc = sat_inc8(cur.retries);

    always_comb begin
        nxt    = cur;
        action = ACT_NONE;
        unique case (kind)
            KIND_SAMPLE_OK: begin
                nxt.fail_streak    = 8'd0;
                nxt.success_streak = ss_inc;
                if (cfg.auto_recover && cur.latched && cur.done &&
                    (ss_inc >= cfg.recover_limit)) begin
                    nxt.latched        = 1'b0;
                    nxt.request        = 1'b0;
                    nxt.done           = 1'b0;
                    nxt.retries        = 8'd0;
                    nxt.gave_up        = 1'b0;
                    nxt.code           = NONE_CODE;
                    nxt.stage          = NONE_CODE;
                    nxt.success_streak = 8'd0;
                    action             = ACT_RECOVER;
                end
            end
            KIND_SAMPLE_FAIL: begin
                nxt.fail_streak    = fs_inc;
                nxt.success_streak = 8'd0;
                nxt.sample_total   = sat_inc16(cur.sample_total);
                nxt.code           = item.err_code;
                nxt.stage          = item.err_stage;
                if ((fs_inc >= cfg.fail_limit) && !cur.latched) begin
                    nxt.latched = 1'b1;
                    nxt.request = 1'b1;
                    nxt.done    = 1'b0;
                    nxt.retries = 8'd0;
                    nxt.gave_up = 1'b0;
                    action      = ACT_ENTER;
                end
            end
            KIND_TAKE: begin
                if (cur.latched && cur.request && !cur.done) begin
                    nxt.request = 1'b0;
                    action      = ACT_SHUTOFF;
                end
            end
            KIND_COMMIT: begin
                if (item.shutoff_status == 8'd0) begin
                    nxt.done    = 1'b1;
                    nxt.request = 1'b0;
                    nxt.gave_up = 1'b0;
                end else begin
                    nxt.done          = 1'b0;
                    nxt.retries       = retry_inc;
                    nxt.shutoff_total = sat_inc16(cur.shutoff_total);
                    nxt.code          = cfg.shutoff_code;
                    nxt.stage         = cfg.shutoff_stage;
                    if (retry_inc < cfg.retry_limit) begin
                        nxt.request = 1'b1;
                        action      = ACT_RETRY;
                    end else begin
                        nxt.gave_up = 1'b1;
                        nxt.request = 1'b0;
                    end
                end
            end
            default: begin
                nxt    = cur;
                action = ACT_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/sample_fault_latch_shutoff_retry_unit.sv =====
// Top level of the battery-monitor sampling fault supervisor.
`timescale 1ns / 1ps

// The supervisor takes one event item per clock cycle and returns one result
// item for each, in the cycle after the item is accepted; throughput is one item
// per cycle for as long as the result side keeps taking items. That figure is
// set by the combinational update of the supervisor state register, which
// holds the fault latch, the shutoff request, the streak and lifetime
// counters and the recorded code and stage. The event kind travels in
// s_tuser, the action of the result in m_tuser. Each result carries the state
// as it stands after its event. A stalled result blocks the input only until
// it is taken: the next item is accepted in the same cycle in which the held
// result leaves. Configuration is written through a plain write port and
// should be changed only while no result is outstanding.

module sample_fault_latch_shutoff_retry_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [sfls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfls_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Event items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0 up: err_code[7:0], err_stage[15:8],
    // driver_return[23:16], shutoff_status[31:24].
    input  logic [sfls_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: kind[1:0].
    input  logic [1:0]                          s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, from bit 0 up: fault_flag[0], pending_flag[1], done_flag[2],
    // gave_up_flag[3], fail_streak[11:4], success_streak[19:12],
    // retries[27:20], sample_fail_total[43:28], shutoff_fail_total[59:44],
    // recorded_code[67:60], recorded_stage[75:68], zero fill[79:76].
    output logic [sfls_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: action[2:0].
    output logic [2:0]                          m_tuser
);
    import sfls_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    action_t action_next;
    item_t   item;
    kind_t   kind;
    logic    accept;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    action_t              m_tuser_reg;

    // The driver return value is carried on the bus but never reported, so
    // only the fields that affect a result are taken from the item.
    assign item.err_code       = s_tdata[7:0];
    assign item.err_stage      = s_tdata[15:8];
    assign item.shutoff_status = s_tdata[31:24];
    assign kind                = kind_t'(s_tuser);

    // The output register is free when empty or being emptied this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sfls_update u_update (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .kind   (kind),
        .item   (item),
        .nxt    (state_next),
        .action (action_next)
    );

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fail_limit    <= FAIL_LIMIT_RST;
            cfg_reg.retry_limit   <= RETRY_LIMIT_RST;
            cfg_reg.recover_limit <= RECOVER_LIMIT_RST;
            cfg_reg.auto_recover  <= AUTO_RECOVER_RST;
            cfg_reg.shutoff_code  <= SHUTOFF_CODE_RST;
            cfg_reg.shutoff_stage <= SHUTOFF_STAGE_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_FAIL_LIMIT:    cfg_reg.fail_limit    <= cfg_wdata;
                REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_wdata;
                REG_RECOVER_LIMIT: cfg_reg.recover_limit <= cfg_wdata;
                REG_AUTO_RECOVER:  cfg_reg.auto_recover  <= cfg_wdata[0];
                REG_SHUTOFF_CODE:  cfg_reg.shutoff_code  <= cfg_wdata;
                REG_SHUTOFF_STAGE: cfg_reg.shutoff_stage <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Supervisor state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: loaded with the post-event state and the action.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tuser_reg <= action_next;
            m_tdata_reg <= {4'd0,
                            state_next.stage,
                            state_next.code,
                            state_next.shutoff_total,
                            state_next.sample_total,
                            state_next.retries,
                            state_next.success_streak,
                            state_next.fail_streak,
                            state_next.gave_up,
                            state_next.done,
                            state_next.request,
                            state_next.latched};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/sfls_checker.sv =====
// Port-level assertions of the supervisor and the bind that attaches them.
`timescale 1ns / 1ps
`include "sample_fault_latch_shutoff_retry_unit_assert.svh"

module sfls_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sfls_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [2:0]                      m_tuser
);
    import sfls_pkg::*;

    // A stalled result holds its contents.
    `SFLS_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Every accepted item yields a result in the next cycle.
    `SFLS_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)

    // Entering the fault latches it and raises the shutoff request.
    `SFLS_ASSERT_NOW(a_enter_flags, m_tvalid && (m_tuser == ACT_ENTER), m_tdata[0] && m_tdata[1])

    // Recovery clears the latch and the good-sample streak.
    `SFLS_ASSERT_NOW(a_recover_clears, m_tvalid && (m_tuser == ACT_RECOVER), !m_tdata[0] && (m_tdata[19:12] == 8'd0))

    // Taking the request leaves no request outstanding, the fault latched.
    `SFLS_ASSERT_NOW(a_take_clears, m_tvalid && (m_tuser == ACT_SHUTOFF), !m_tdata[1] && m_tdata[0])

endmodule

bind sample_fault_latch_shutoff_retry_unit sfls_checker u_sfls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/sfls_scoreboard.sv =====
// Result checker for the sampling fault supervisor: predicts every result item and compares it.
`timescale 1ns / 1ps

module sfls_scoreboard (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfls_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sfls_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sfls_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [2:0]                      m_tuser,
    output int                              outstanding,
    output int                              mismatches,
    output int                              results_checked
);
    import sfls_pkg::*;

    typedef struct {
        action_t     action;
        logic        latched;
        logic        pending;
        logic        done;
        logic        gave_up;
        logic [7:0]  fail_streak;
        logic [7:0]  good_streak;
        logic [7:0]  retries;
        logic [15:0] sample_fails;
        logic [15:0] shutoff_fails;
        logic [7:0]  code;
        logic [7:0]  stage;
    } outcome_t;

    // Settings as the supervisor sees them.
    logic [7:0] lim_fail, lim_retry, lim_recover, fail_code_cfg, fail_stage_cfg;
    logic       auto_on;

    // Supervisor state as predicted.
    logic        latched, shutoff_req, shutoff_done, gave_up;
    logic [7:0]  fail_run, good_run, retry_cnt, code_rec, stage_rec;
    logic [15:0] sample_fails, shutoff_fails;

    outcome_t outcome_q[$];
    int       fail_total = 0;
    int       seen = 0;

    initial begin
        outstanding = 0;
        mismatches = 0;
        results_checked = 0;
    end

    function automatic logic [7:0] bump8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic clear_model();
        lim_fail = FAIL_LIMIT_RST;
        lim_retry = RETRY_LIMIT_RST;
        lim_recover = RECOVER_LIMIT_RST;
        auto_on = AUTO_RECOVER_RST;
        fail_code_cfg = SHUTOFF_CODE_RST;
        fail_stage_cfg = SHUTOFF_STAGE_RST;
        latched = 1'b0;
        shutoff_req = 1'b0;
        shutoff_done = 1'b0;
        gave_up = 1'b0;
        fail_run = '0;
        good_run = '0;
        retry_cnt = '0;
        code_rec = NONE_CODE;
        stage_rec = NONE_CODE;
        sample_fails = '0;
        shutoff_fails = '0;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            REG_FAIL_LIMIT:    lim_fail = val;
            REG_RETRY_LIMIT:   lim_retry = val;
            REG_RECOVER_LIMIT: lim_recover = val;
            REG_AUTO_RECOVER:  auto_on = val[0];
            REG_SHUTOFF_CODE:  fail_code_cfg = val;
            REG_SHUTOFF_STAGE: fail_stage_cfg = val;
            default: ;
        endcase
    endtask

    // Applies one event to the predicted state and returns the result it must produce.
    function automatic outcome_t step_event(input kind_t kind, input logic [31:0] d);
        outcome_t   r;
        logic [7:0] status;
        status = d[31:24];
        r.action = ACT_NONE;
        case (kind)
            KIND_SAMPLE_OK: begin
                fail_run = '0;
                good_run = bump8(good_run);
                if (auto_on && latched && good_run >= lim_recover && shutoff_done) begin
                    latched = 1'b0;
                    shutoff_req = 1'b0;
                    shutoff_done = 1'b0;
                    retry_cnt = '0;
                    gave_up = 1'b0;
                    code_rec = NONE_CODE;
                    stage_rec = NONE_CODE;
                    good_run = '0;
                    r.action = ACT_RECOVER;
                end
            end
            KIND_SAMPLE_FAIL: begin
                fail_run = bump8(fail_run);
                good_run = '0;
                sample_fails = bump16(sample_fails);
                code_rec = d[7:0];
                stage_rec = d[15:8];
                if (fail_run >= lim_fail && !latched) begin
                    latched = 1'b1;
                    shutoff_req = 1'b1;
                    shutoff_done = 1'b0;
                    retry_cnt = '0;
                    gave_up = 1'b0;
                    r.action = ACT_ENTER;
                end
            end
            KIND_TAKE: begin
                if (latched && shutoff_req && !shutoff_done) begin
                    shutoff_req = 1'b0;
                    r.action = ACT_SHUTOFF;
                end
            end
            default: begin
                // A commit is recorded even when no fault is latched.
                if (status == 8'd0) begin
                    shutoff_done = 1'b1;
                    shutoff_req = 1'b0;
                    gave_up = 1'b0;
                end else begin
                    shutoff_done = 1'b0;
                    retry_cnt = bump8(retry_cnt);
                    shutoff_fails = bump16(shutoff_fails);
                    code_rec = fail_code_cfg;
                    stage_rec = fail_stage_cfg;
                    if (retry_cnt < lim_retry) begin
                        shutoff_req = 1'b1;
                        r.action = ACT_RETRY;
                    end else begin
                        gave_up = 1'b1;
                        shutoff_req = 1'b0;
                    end
                end
            end
        endcase
        r.latched = latched;
        r.pending = shutoff_req;
        r.done = shutoff_done;
        r.gave_up = gave_up;
        r.fail_streak = fail_run;
        r.good_streak = good_run;
        r.retries = retry_cnt;
        r.sample_fails = sample_fails;
        r.shutoff_fails = shutoff_fails;
        r.code = code_rec;
        r.stage = stage_rec;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            note_failure($sformatf("result %0d field %s expected 0x%0h got 0x%0h",
                                   seen, name, want, got));
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            clear_model();
            outcome_q.delete();
        end else begin
            // The result side goes first: a result taken at this edge belongs to an older item.
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with no item waiting", seen));
                end else begin
                    want = outcome_q.pop_front();
                    check_field("action", want.action, m_tuser);
                    check_field("fault_flag", want.latched, m_tdata[0]);
                    check_field("pending_flag", want.pending, m_tdata[1]);
                    check_field("done_flag", want.done, m_tdata[2]);
                    check_field("gave_up_flag", want.gave_up, m_tdata[3]);
                    check_field("fail_streak", want.fail_streak, m_tdata[11:4]);
                    check_field("success_streak", want.good_streak, m_tdata[19:12]);
                    check_field("retries", want.retries, m_tdata[27:20]);
                    check_field("sample_fail_total", want.sample_fails, m_tdata[43:28]);
                    check_field("shutoff_fail_total", want.shutoff_fails, m_tdata[59:44]);
                    check_field("recorded_code", want.code, m_tdata[67:60]);
                    check_field("recorded_stage", want.stage, m_tdata[75:68]);
                end
                seen++;
            end
            if (cfg_wr_en) begin
                write_setting(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(step_event(kind_t'(s_tuser), s_tdata));
            end
        end
        outstanding <= outcome_q.size();
        mismatches <= fail_total;
        results_checked <= seen;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the sampling fault supervisor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import sfls_pkg::*;

    // An index that maps to no register; writes to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;

    int outstanding;
    int mismatches;
    int results_checked;

    // Stimulus bookkeeping. The limit copies only shape the bursts; they predict nothing.
    int          sent = 0;
    int          settings_used = 1;
    int unsigned fail_lim = FAIL_LIMIT_RST;
    int unsigned retry_lim = RETRY_LIMIT_RST;
    int unsigned recover_lim = RECOVER_LIMIT_RST;
    bit          calm = 1'b0;
    int unsigned ready_run = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sample_fault_latch_shutoff_retry_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sfls_scoreboard scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .outstanding     (outstanding),
        .mismatches      (mismatches),
        .results_checked (results_checked)
    );

    // The result side alternates between ready and stalled stretches of random
    // length, and some ready stretches run long enough to let the block stream
    // at full rate.
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                m_tready <= 1'b1;
                ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b0;
                ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Builds the event data word: fault code in the low byte, then the stage,
    // the driver return value and the shutoff status in the top byte.
    function automatic logic [31:0] event_word(input logic [7:0] code, input logic [7:0] stage,
                                               input logic [7:0] ret, input logic [7:0] status);
        return {status, ret, stage, code};
    endfunction

    // Offers one item and holds it until the block takes it. Before the item
    // the sender may sit idle for a while, unless the current stretch is calm.
    task automatic send_event(input kind_t kind, input logic [31:0] data);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        gap = 0;
        if (!calm) begin
            if (pick >= 92) begin
                gap = $urandom_range(8, 40);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Stops sending and waits until every result already owed has been taken.
    // The first edge is always waited out, so an item taken at the current edge
    // is already counted in the outstanding figure when it is first looked at.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Moves the block to a new setting while it is idle. The auto-recover write
    // carries random upper bits, which the block must ignore, and a write to an
    // unmapped index follows that must change nothing.
    task automatic apply_settings(input int unsigned fl, input int unsigned rl,
                                  input int unsigned rcl, input bit ar,
                                  input logic [7:0] code, input logic [7:0] stage);
        hold_until_drained();
        repeat (2) @(posedge aclk);
        write_reg(REG_FAIL_LIMIT, fl[7:0]);
        write_reg(REG_RETRY_LIMIT, rl[7:0]);
        write_reg(REG_RECOVER_LIMIT, rcl[7:0]);
        write_reg(REG_AUTO_RECOVER, {7'($urandom), ar});
        write_reg(REG_SHUTOFF_CODE, code);
        write_reg(REG_SHUTOFF_STAGE, stage);
        write_reg(REG_UNMAPPED, 8'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        fail_lim = fl & 8'hFF;
        retry_lim = rl & 8'hFF;
        recover_lim = rcl & 8'hFF;
        settings_used++;
    endtask

    // Length of a burst aimed at a limit: half of the bursts reach or just pass
    // it, the rest take a random length from one up to one past it.
    function automatic int unsigned burst_length(input int unsigned limit);
        int unsigned len;
        len = ($urandom_range(0, 1) == 1) ? limit + $urandom_range(0, 2)
                                          : $urandom_range(1, limit + 1);
        return (len == 0) ? 1 : len;
    endfunction

    // Random traffic built from the sequences that carry the supervisor through
    // its states: failure bursts that latch the fault, take and commit pairs,
    // runs of failed shutoffs that exhaust the retries, good-sample runs that allow
    // recovery, a share of noise with any kind and any data, and rare pauses to drain.
    task automatic run_random(input int budget);
        int          start;
        int unsigned pick;
        int unsigned len;
        start = sent;
        while (sent - start < budget) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                hold_until_drained();
            end else if (pick < 27) begin
                len = burst_length(fail_lim);
                repeat (len) send_event(KIND_SAMPLE_FAIL, $urandom);
            end else if (pick < 50) begin
                send_event(KIND_TAKE, $urandom);
                send_event(KIND_COMMIT,
                           {($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom), 24'($urandom)});
            end else if (pick < 60) begin
                len = burst_length(retry_lim);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_event(KIND_TAKE, $urandom);
                    end
                    send_event(KIND_COMMIT, {8'($urandom_range(1, 255)), 24'($urandom)});
                end
            end else if (pick < 80) begin
                len = burst_length(recover_lim);
                repeat (len) send_event(KIND_SAMPLE_OK, $urandom);
            end else begin
                repeat ($urandom_range(1, 4)) send_event(kind_t'($urandom_range(0, 3)), $urandom);
            end
        end
        calm = 1'b0;
    endtask

    // Overall time limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk with the reset settings (fail limit 3, retry limit 3,
        // no auto recovery). It opens with a take that has no request behind it
        // and commits that arrive with no fault latched, then latches a fault,
        // fails again while latched, and runs the shutoff through retries to
        // give-up and a final success. Field values cover all zeros and all ones.
        calm = 1'b1;
        send_event(KIND_TAKE, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_COMMIT, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_COMMIT, event_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_event(KIND_SAMPLE_OK, event_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_event(KIND_SAMPLE_FAIL, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_SAMPLE_FAIL, event_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_event(KIND_SAMPLE_FAIL, event_word(8'h5A, 8'hA5, 8'h3C, 8'hC3));
        send_event(KIND_SAMPLE_FAIL, event_word(8'h12, 8'h34, 8'h56, 8'h78));
        send_event(KIND_TAKE, event_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_event(KIND_TAKE, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_COMMIT, event_word(8'h00, 8'h00, 8'h00, 8'h07));
        send_event(KIND_TAKE, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_COMMIT, event_word(8'h00, 8'h00, 8'h00, 8'h80));
        send_event(KIND_COMMIT, event_word(8'h00, 8'h00, 8'h00, 8'h01));
        send_event(KIND_TAKE, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_COMMIT, event_word(8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_event(KIND_SAMPLE_OK, event_word(8'h00, 8'h00, 8'h00, 8'h00));
        send_event(KIND_SAMPLE_FAIL, event_word(8'hAA, 8'h55, 8'hAA, 8'h55));
        send_event(KIND_SAMPLE_OK, event_word(8'h55, 8'hAA, 8'h55, 8'hAA));
        calm = 1'b0;

        // The sender holds back once on purpose until every result is in.
        hold_until_drained();
        run_random(110);

        // Smallest nonzero limits with auto recovery, then zero limits, where
        // the first failure latches, the first failed shutoff gives up and any
        // good sample after success recovers.
        apply_settings(1, 1, 1, 1'b1, 8'hFF, 8'h00);
        run_random(110);
        apply_settings(0, 0, 0, 1'b1, 8'h00, 8'hFF);
        run_random(110);

        // Full-scale limits: long bursts here also saturate the streak and
        // retry counters.
        apply_settings(255, 255, 255, 1'b1, 8'hA5, 8'h5A);
        run_random(300);

        // Two random small settings, then a fixed mid setting with recovery off.
        apply_settings($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                       1'b1, 8'($urandom), 8'($urandom));
        run_random(110);
        apply_settings($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                       1'($urandom), 8'($urandom), 8'($urandom));
        run_random(110);
        apply_settings(2, 5, 3, 1'b0, 8'h3C, 8'hC3);
        run_random(110);

        // Let every owed result come back, then keep watching for anything the
        // block should not have sent.
        hold_until_drained();
        repeat (4) @(posedge aclk);

        $display("Covered %0d event items over %0d settings, zero and full-scale limits included.",
                 sent, settings_used);
        $display("Checked %0d result items against the predicted supervisor state.",
                 results_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Failures: %0d mismatches, %0d results missing.", mismatches, outstanding);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
